FILE: rtl/cct_pkg.sv
package cct_pkg;
    localparam int Cities = 10;
    localparam int CityW = 4;
    localparam int TourW = 40;
    localparam int CostW = 10;
    localparam int SumW = 14;
    localparam int AddrW = 7;
    localparam int Depth = Cities * Cities;
    localparam int PosW = 4;
    localparam int StepW = 5;
    localparam logic [SumW-1:0] CostMax = {SumW{1'b1}};

    localparam logic [1:0] CmdWrite = 2'd0;
    localparam logic [1:0] CmdCross = 2'd1;
    localparam logic [1:0] CmdClear = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CityW-1:0] from_city;
        logic [CityW-1:0] to_city;
        logic [CostW-1:0] cost_value;
        logic [TourW-1:0] pa;
        logic [TourW-1:0] pb;
    } t_item;

    function automatic logic [CityW-1:0] city_at(logic [TourW-1:0] t, logic [PosW-1:0] p);
        city_at = t[p*CityW +: CityW];
    endfunction
endpackage

FILE: rtl/cycle_crossover_tour_cost.sv
// Cycle crossover with tour costing. Assert start with an item while busy is
// low; a cross item runs, per child, the cycle-follow steps, one fill, the
// cost-table reads through the single RAM read port and one emit. Two results
// follow on o_strobe, each for one cycle; the receiver cannot stall them.
module cycle_crossover_tour_cost import cct_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_cmd,
    input  logic [CityW-1:0] i_from_city,
    input  logic [CityW-1:0] i_to_city,
    input  logic [CostW-1:0] i_cost_value,
    input  logic [TourW-1:0] i_parent_first,
    input  logic [TourW-1:0] i_parent_second,
    output logic             o_strobe,
    output logic [TourW-1:0] o_child_tour,
    output logic [SumW-1:0]  o_child_cost,
    output logic             o_new_best,
    output logic             o_bad_tour,
    output logic [SumW-1:0]  o_best_cost,
    output logic             o_last
);
    t_item in_item, q_item;
    logic full, q_valid, pop, bbusy;
    assign in_item = '{cmd: i_cmd, from_city: i_from_city, to_city: i_to_city,
        cost_value: i_cost_value, pa: i_parent_first, pb: i_parent_second};
    assign busy = full || bbusy;

    cct_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_item(in_item), .o_full(full), .o_valid(q_valid), .o_item(q_item), .i_pop(pop));

    cct_back u_back (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid),
        .i_item(q_item), .o_pop(pop), .o_busy(bbusy), .o_strobe(o_strobe),
        .o_child_tour(o_child_tour), .o_child_cost(o_child_cost),
        .o_new_best(o_new_best), .o_bad_tour(o_bad_tour),
        .o_best_cost(o_best_cost), .o_last(o_last));
endmodule

FILE: rtl/cct_ram.sv
module cct_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    localparam int AW = $clog2(Depth)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/cct_front.sv
module cct_front import cct_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);
    logic  r_valid;
    t_item r_item;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_start && !r_valid && (i_item.cmd == CmdWrite ||
                i_item.cmd == CmdCross || i_item.cmd == CmdClear)) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
        if (i_start && !r_valid) r_item <= i_item;
    end
    assign o_full = r_valid;
    assign o_valid = r_valid;
    assign o_item = r_item;
endmodule

FILE: rtl/cct_back.sv
module cct_back import cct_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_busy,
    output logic             o_strobe,
    output logic [TourW-1:0] o_child_tour,
    output logic [SumW-1:0]  o_child_cost,
    output logic             o_new_best,
    output logic             o_bad_tour,
    output logic [SumW-1:0]  o_best_cost,
    output logic             o_last
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_CYC = 5'b00010, S_FILL = 5'b00100,
        S_COST = 5'b01000, S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    logic [TourW-1:0] r_keep, r_other, r_child, r_best_tour;
    logic [Cities-1:0] r_filled;
    logic [CityW-1:0] r_loc;
    logic [StepW-1:0] r_step;
    logic r_bad, r_closed, r_second;
    logic [SumW-1:0] r_best, r_sum;
    logic [PosW-1:0] r_pos;
    logic r_rd_ok;
    logic [CostW-1:0] rdata;
    logic [AddrW-1:0] raddr;
    logic [CityW-1:0] ca, cb;
    logic [PosW-1:0] nxt;
    logic found;
    logic [PosW-1:0] fpos;
    logic we;
    logic [SumW:0] add;

    assign we = i_valid && r_state == S_IDLE && i_item.cmd == CmdWrite &&
        i_item.from_city < Cities && i_item.to_city < Cities;

    cct_ram #(.Width(CostW), .Depth(Depth)) u_ram (
        .i_clk(i_clk), .i_we(we),
        .i_waddr(AddrW'(i_item.from_city * Cities + i_item.to_city)),
        .i_wdata(i_item.cost_value), .i_raddr(raddr), .o_rdata(rdata));

    always_comb begin
        found = 1'b0;
        fpos = '0;
        for (int j = Cities - 1; j >= 0; j--) begin
            if (city_at(r_keep, PosW'(j)) == r_loc) begin
                found = 1'b1;
                fpos = PosW'(j);
            end
        end
        nxt = (r_pos == PosW'(Cities - 1)) ? '0 : r_pos + 1'b1;
        ca = city_at(r_child, r_pos);
        cb = city_at(r_child, nxt);
        raddr = AddrW'(ca * Cities + cb);
        add = {1'b0, r_sum} + (r_rd_ok ? (SumW+1)'(rdata) : '0);
    end

    assign o_busy = r_state != S_IDLE || i_valid;
    assign o_pop = i_valid && r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
            r_state <= S_IDLE;
            r_best <= CostMax;
            r_best_tour <= '0;
        end else begin
            o_strobe <= r_state == S_EMIT;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && i_item.cmd == CmdClear) begin
                        r_best <= CostMax;
                        r_best_tour <= '0;
                    end else if (i_valid && i_item.cmd == CmdCross) begin
                        r_keep <= i_item.pa;
                        r_other <= i_item.pb;
                        r_child <= {{(TourW-CityW){1'b0}}, i_item.pa[CityW-1:0]};
                        r_filled <= Cities'(1);
                        r_loc <= i_item.pb[CityW-1:0];
                        r_step <= '0;
                        r_bad <= 1'b0;
                        r_closed <= 1'b0;
                        r_second <= 1'b0;
                        r_state <= S_CYC;
                    end
                end
                S_CYC: begin
                    if (r_step == StepW'(Cities) || r_closed || r_bad) begin
                        if (!r_closed) r_bad <= 1'b1;
                        r_pos <= '0;
                        r_state <= S_FILL;
                    end else begin
                        r_step <= r_step + 1'b1;
                        if (!found) r_bad <= 1'b1;
                        else if (r_filled[fpos]) r_closed <= 1'b1;
                        else begin
                            r_child[fpos*CityW +: CityW] <= r_loc;
                            r_filled[fpos] <= 1'b1;
                            r_loc <= city_at(r_other, fpos);
                        end
                    end
                end
                S_FILL: begin
                    for (int p = 0; p < Cities; p++)
                        if (!r_filled[p]) r_child[p*CityW +: CityW] <= city_at(r_other, PosW'(p));
                    r_pos <= '0;
                    r_sum <= '0;
                    r_rd_ok <= 1'b0;
                    r_state <= S_COST;
                end
                S_COST: begin
                    r_sum <= add[SumW] ? CostMax : add[SumW-1:0];
                    r_rd_ok <= r_pos < PosW'(Cities) && ca < Cities && cb < Cities;
                    if (r_rd_ok || r_pos != '0 || r_step != '1) begin
                        r_step <= '1;
                        if (r_pos == PosW'(Cities - 1)) r_pos <= PosW'(Cities);
                        else if (r_pos == PosW'(Cities)) r_state <= S_EMIT;
                        else r_pos <= r_pos + 1'b1;
                    end
                end
                S_EMIT: begin
                    o_child_tour <= r_child;
                    o_child_cost <= r_sum;
                    o_bad_tour <= r_bad;
                    o_last <= r_second;
                    if (!r_bad && r_sum < r_best) begin
                        r_best <= r_sum;
                        r_best_tour <= r_child;
                        o_best_cost <= r_sum;
                        o_new_best <= 1'b1;
                    end else begin
                        o_best_cost <= r_best;
                        o_new_best <= 1'b0;
                    end
                    if (r_second) r_state <= S_IDLE;
                    else begin
                        r_second <= 1'b1;
                        r_keep <= r_other;
                        r_other <= r_keep;
                        r_child <= {{(TourW-CityW){1'b0}}, r_other[CityW-1:0]};
                        r_filled <= Cities'(1);
                        r_loc <= r_keep[CityW-1:0];
                        r_step <= '0;
                        r_bad <= 1'b0;
                        r_closed <= 1'b0;
                        r_state <= S_CYC;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sim/tb_cycle_crossover_tour_cost.sv
module tb_cycle_crossover_tour_cost;
    import cct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [TourW-1:0] tour;
        logic [SumW-1:0]  cost;
        logic             nb;
        logic             bad;
        logic [SumW-1:0]  best;
        logic             last;
        bit               hint_on;
        logic             hint_bad;
    } t_child;

    typedef struct {
        logic [1:0]       cmd;
        logic [CityW-1:0] fc;
        logic [CityW-1:0] tc;
        logic [CostW-1:0] cv;
        logic [TourW-1:0] pa;
        logic [TourW-1:0] pb;
        bit               hint_on;
        logic             hint_bad;
    } t_row;

    localparam logic [1:0] CmdNop = 2'd3;
    localparam logic [TourW-1:0] Ident = 40'h9876543210;
    localparam logic [TourW-1:0] Revrs = 40'h0123456789;
    localparam logic [TourW-1:0] AllF  = {TourW{1'b1}};
    localparam int WatchLimit = 4000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_cmd = CmdNop;
    logic [CityW-1:0] i_from_city = '0;
    logic [CityW-1:0] i_to_city = '0;
    logic [CostW-1:0] i_cost_value = '0;
    logic [TourW-1:0] i_parent_first = '0;
    logic [TourW-1:0] i_parent_second = '0;
    logic             o_strobe;
    logic [TourW-1:0] o_child_tour;
    logic [SumW-1:0]  o_child_cost;
    logic             o_new_best;
    logic             o_bad_tour;
    logic [SumW-1:0]  o_best_cost;
    logic             o_last;

    logic [CostW-1:0] cost_tbl [Depth];
    logic [TourW-1:0] best_tour_m;
    logic [SumW-1:0]  best_cost_m;
    t_child           child_q[$];
    int               errors = 0;
    int               idle_cycles = 0;

    cycle_crossover_tour_cost dut (.*);

    always #4 i_clk = ~i_clk;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [TourW-1:0] cross_child(logic [TourW-1:0] keep,
            logic [TourW-1:0] other, output logic bad);
        logic [TourW-1:0] child;
        bit               filled [Cities];
        logic [CityW-1:0] seek;
        int               found;
        bit               closed;
        child = '0;
        closed = 0;
        bad = 0;
        foreach (filled[i]) filled[i] = 0;
        child[3:0] = keep[3:0];
        filled[0] = 1;
        seek = other[3:0];
        for (int s = 0; s < Cities && !closed && !bad; s++) begin
            found = -1;
            for (int j = 0; j < Cities; j++) begin
                if (found < 0 && keep[j*CityW +: CityW] == seek) found = j;
            end
            if (found < 0) begin
                bad = 1;
            end else if (filled[found]) begin
                closed = 1;
            end else begin
                child[found*CityW +: CityW] = seek;
                filled[found] = 1;
                seek = other[found*CityW +: CityW];
            end
        end
        if (!closed) bad = 1;
        for (int p = 0; p < Cities; p++) begin
            if (!filled[p]) child[p*CityW +: CityW] = other[p*CityW +: CityW];
        end
        return child;
    endfunction

    function automatic logic [SumW-1:0] tour_cost(logic [TourW-1:0] t);
        int a;
        int b;
        int sum;
        sum = 0;
        for (int p = 0; p < Cities; p++) begin
            a = t[p*CityW +: CityW];
            b = t[((p + 1) % Cities)*CityW +: CityW];
            if (a < Cities && b < Cities) sum += cost_tbl[a*Cities + b];
        end
        return (sum > CostMax) ? CostMax : sum[SumW-1:0];
    endfunction

    task automatic push_child(logic [TourW-1:0] t, logic bad, logic last, t_row r);
        t_child c;
        c.tour = t;
        c.cost = tour_cost(t);
        c.nb = 1'b0;
        if (!bad && c.cost < best_cost_m) begin
            best_cost_m = c.cost;
            best_tour_m = t;
            c.nb = 1'b1;
        end
        c.bad = bad;
        c.best = best_cost_m;
        c.last = last;
        c.hint_on = r.hint_on;
        c.hint_bad = r.hint_bad;
        child_q.push_back(c);
    endtask

    task automatic predict(t_row r);
        logic [TourW-1:0] c1;
        logic [TourW-1:0] c2;
        logic             b1;
        logic             b2;
        case (r.cmd)
            CmdWrite: begin
                if (r.fc < Cities && r.tc < Cities) cost_tbl[r.fc*Cities + r.tc] = r.cv;
            end
            CmdClear: begin
                best_tour_m = '0;
                best_cost_m = CostMax;
            end
            CmdCross: begin
                c1 = cross_child(r.pa, r.pb, b1);
                c2 = cross_child(r.pb, r.pa, b2);
                push_child(c1, b1, 1'b0, r);
                push_child(c2, b2, 1'b1, r);
            end
            default: ;
        endcase
    endtask

    task automatic send(t_row r, int gap);
        if (gap > 0) begin
            @(negedge i_clk) start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cmd = r.cmd;
        i_from_city = r.fc;
        i_to_city = r.tc;
        i_cost_value = r.cv;
        i_parent_first = r.pa;
        i_parent_second = r.pb;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        predict(r);
    endtask

    function automatic t_row mk(logic [1:0] cmd, logic [CityW-1:0] fc, logic [CityW-1:0] tc,
            logic [CostW-1:0] cv, logic [TourW-1:0] pa, logic [TourW-1:0] pb);
        t_row r;
        r.cmd = cmd;
        r.fc = fc;
        r.tc = tc;
        r.cv = cv;
        r.pa = pa;
        r.pb = pb;
        r.hint_on = 0;
        r.hint_bad = 1'b0;
        return r;
    endfunction

    function automatic logic [TourW-1:0] rand_tour();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TourW-1:0];
    endfunction

    function automatic logic [TourW-1:0] shuffle();
        int perm [Cities];
        int k;
        int tmp;
        logic [TourW-1:0] t;
        foreach (perm[i]) perm[i] = i;
        for (int i = Cities - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[k];
            perm[k] = tmp;
        end
        foreach (perm[i]) t[i*CityW +: CityW] = CityW'(perm[i]);
        return t;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_child w;
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("tb_cycle_crossover_tour_cost NOT OK");
                $finish;
            end
            if (o_strobe) begin
                if (child_q.size() == 0) begin
                    report("unexpected beat", o_child_tour, 0);
                end else begin
                    w = child_q.pop_front();
                    if (o_child_tour !== w.tour) report("child_tour", o_child_tour, w.tour);
                    if (o_child_cost !== w.cost) report("child_cost", o_child_cost, w.cost);
                    if (o_new_best !== w.nb) report("new_best", o_new_best, w.nb);
                    if (o_bad_tour !== w.bad) report("bad_tour", o_bad_tour, w.bad);
                    if (o_best_cost !== w.best) report("best_cost", o_best_cost, w.best);
                    if (o_last !== w.last) report("last", o_last, w.last);
                    if (w.hint_on && o_bad_tour !== w.hint_bad)
                        report("bad_tour vs table", o_bad_tour, w.hint_bad);
                end
            end
        end
    end

    initial begin
        t_row rows [$];
        t_row r;
        int   sel;
        best_tour_m = '0;
        best_cost_m = CostMax;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // fill every entry before any crossing reads the table
        for (int a = 0; a < Cities; a++) begin
            for (int b = 0; b < Cities; b++) begin
                send(mk(CmdWrite, CityW'(a), CityW'(b), CostW'($urandom_range(0, 1023)),
                        '0, '0), pick_gap());
            end
        end

        rows.push_back(mk(CmdWrite, '0, '0, 10'd0, '0, '0));
        rows.push_back(mk(CmdWrite, 4'd9, 4'd9, 10'd1023, '0, '0));
        rows.push_back(mk(CmdWrite, 4'd15, 4'd3, 10'd77, AllF, AllF));
        rows.push_back(mk(CmdWrite, 4'd2, 4'd12, 10'd1023, '0, '0));
        rows.push_back(mk(CmdNop, 4'd15, 4'd15, 10'd1023, AllF, AllF));
        r = mk(CmdCross, '0, '0, '0, AllF, AllF);
        r.hint_on = 1;
        r.hint_bad = 1'b0;
        rows.push_back(r);
        rows.push_back(mk(CmdClear, '0, '0, '0, '0, '0));
        rows.push_back(mk(CmdCross, '0, '0, '0, Ident, Ident));
        rows.push_back(mk(CmdCross, '0, '0, '0, Ident, Revrs));
        r = mk(CmdCross, '0, '0, '0, Ident, AllF);
        r.hint_on = 1;
        r.hint_bad = 1'b1;
        rows.push_back(r);
        rows.push_back(mk(CmdCross, '0, '0, '0, '0, '0));
        rows.push_back(mk(CmdCross, '0, '0, '0, AllF, '0));
        rows.push_back(mk(CmdCross, '0, '0, '0, Revrs, shuffle()));
        rows.push_back(mk(CmdCross, '0, '0, '0, shuffle(), shuffle()));
        rows.push_back(mk(CmdClear, '0, '0, '0, '0, '0));
        rows.push_back(mk(CmdCross, '0, '0, '0, shuffle(), shuffle()));
        foreach (rows[i]) send(rows[i], pick_gap());

        @(negedge i_clk) start = 1'b0;
        while (child_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);

        for (int n = 0; n < 334; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                r = mk(CmdWrite, CityW'($urandom_range(0, Cities - 1)),
                       CityW'($urandom_range(0, Cities - 1)),
                       CostW'($urandom_range(0, 1023)), rand_tour(), rand_tour());
            end else if (sel < 18) begin
                r = mk(CmdWrite, CityW'($urandom_range(0, 15)), CityW'($urandom_range(0, 15)),
                       CostW'($urandom_range(0, 1023)), '0, '0);
            end else if (sel < 20) begin
                r = mk(CmdNop, CityW'($urandom_range(0, 15)), CityW'($urandom_range(0, 15)),
                       CostW'($urandom_range(0, 1023)), rand_tour(), rand_tour());
            end else if (sel < 23) begin
                r = mk(CmdClear, '0, '0, '0, '0, '0);
            end else if (sel < 82) begin
                r = mk(CmdCross, '0, '0, '0, shuffle(), shuffle());
            end else if (sel < 92) begin
                r = mk(CmdCross, '0, '0, '0, shuffle(), shuffle());
                r.pa[$urandom_range(0, Cities - 1)*CityW +: CityW] =
                    CityW'($urandom_range(0, 15));
            end else begin
                r = mk(CmdCross, '0, '0, '0, rand_tour(), rand_tour());
            end
            send(r, pick_gap());
        end

        @(negedge i_clk) start = 1'b0;
        while (child_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_cycle_crossover_tour_cost OK");
        end else begin
            $display("tb_cycle_crossover_tour_cost NOT OK");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/cct_pkg.sv
rtl/cct_ram.sv
rtl/cct_front.sv
rtl/cct_back.sv
rtl/cycle_crossover_tour_cost.sv
sim/tb_cycle_crossover_tour_cost.sv
